// File: hw/rtl/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

    // Default coordinate width of the stored position and velocity
    localparam int COORD_WIDTH_DEF = 32;

    // Fixed widths of the ports
    localparam int IN_W    = 32;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 2;

    // Arithmetic widths: magnitudes below 2^31, products, sum of squares
    localparam int MUL_W   = 31;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = ROOT_W + 2;

    // Vector components
    localparam int VEC_N    = 3;
    localparam int LAST_IDX = VEC_N - 1;

    // Iteration counts of the root and divide units
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = MUL_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_RADIUS = 2'd2;

    localparam logic [CFG_W-1:0] HIT_RADIUS_RST = 31'd131072;

    // Opcodes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LAUNCH = 2'd1,
        OP_LOADV  = 2'd2
    } op_t;

    // Datapath operations
    typedef enum logic [4:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_LAUNCH,
        DP_LOADV,
        DP_DIFF,
        DP_MAG,
        DP_SHIFT,
        DP_SQ,
        DP_ACC,
        DP_LIMSQ,
        DP_HIT,
        DP_TLATCH,
        DP_ZERO,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_MULQ,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_STORE,
        DP_SUBV,
        DP_ADDV,
        DP_SETV,
        DP_MOVE,
        DP_OUT
    } dp_op_t;

    // Which limit feeds the multiplier
    typedef enum logic [1:0] {
        LIM_SPEED,
        LIM_FORCE,
        LIM_RADIUS
    } lim_t;

    typedef struct packed {
        dp_op_t      op;
        logic [1:0]  idx;
        lim_t        lim;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       mag_small;
        logic       big;
        logic       acc_zero;
        logic       acc_gt;
    } sts_t;

endpackage

// File: hw/rtl/seek_steering_step.sv
`timescale 1ns / 1ps
// Launch, velocity load and the unused opcode pass from accept through the dispatch state to
// the output state. A tick runs four length checks with up to COORD_WIDTH-29 normalizing
// shifts each, and up to three rescales, each a 32-step root and three 31-step divides.
// One word at a time: the next word is accepted once the result is registered, also while
// that result waits.
// Reset (rst_n, async low): state and active flag clear, limits clear, hit_radius 2.0.

module seek_steering_step #(
    parameter int COORD_WIDTH = sss_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sss_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic signed [sss_pkg::IN_W-1:0]   vec_x,
    input  logic signed [sss_pkg::IN_W-1:0]   vec_y,
    input  logic signed [sss_pkg::IN_W-1:0]   vec_z,
    input  logic                              target_present,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [sss_pkg::IN_W-1:0]   pos_x,
    output logic signed [sss_pkg::IN_W-1:0]   pos_y,
    output logic signed [sss_pkg::IN_W-1:0]   pos_z,
    output logic signed [sss_pkg::IN_W-1:0]   vel_x,
    output logic signed [sss_pkg::IN_W-1:0]   vel_y,
    output logic signed [sss_pkg::IN_W-1:0]   vel_z,
    output logic                              is_active,
    output logic                              hit
);

    sss_pkg::cmd_t cmd;
    sss_pkg::sts_t sts;

    // Sequencer
    sss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Vector arithmetic and state
    sss_dpath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .vec_x          (vec_x),
        .vec_y          (vec_y),
        .vec_z          (vec_z),
        .target_present (target_present),
        .cmd            (cmd),
        .sts            (sts),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .vel_z          (vel_z),
        .is_active      (is_active),
        .hit            (hit)
    );

endmodule

// File: hw/rtl/sss_ctrl.sv
`timescale 1ns / 1ps

module sss_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  sss_pkg::sts_t   sts,
    output sss_pkg::cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIFF,
        S_MAG,
        S_SHIFT,
        S_SQ,
        S_ACC,
        S_LIM,
        S_DECIDE,
        S_TLATCH,
        S_ZERO,
        S_SQRT_INIT,
        S_SQRT,
        S_MULQ,
        S_DIV_INIT,
        S_DIV,
        S_STORE,
        S_NEXT,
        S_MOVE,
        S_OUT
    } state_t;

    // Which vector the shared clamp sequence is working on
    typedef enum logic [1:0] {
        PH_HIT,
        PH_DESIRE,
        PH_FORCE,
        PH_SPEED
    } phase_t;

    state_t                     state_reg;
    phase_t                     phase_reg;
    logic [sss_pkg::CNT_W-1:0]  cnt_reg;
    logic [1:0]                 idx_reg;
    logic                       out_valid_reg;
    logic                       out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // Command decode
    always_comb
    begin
        cmd.op  = sss_pkg::DP_NONE;
        cmd.idx = idx_reg;
        unique case (phase_reg)
            PH_HIT:   cmd.lim = sss_pkg::LIM_RADIUS;
            PH_FORCE: cmd.lim = sss_pkg::LIM_FORCE;
            default:  cmd.lim = sss_pkg::LIM_SPEED;
        endcase
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = sss_pkg::DP_CAPTURE;
                end
            end
            S_DISPATCH:
            begin
                case (sts.opcode)
                    sss_pkg::OP_LAUNCH: cmd.op = sss_pkg::DP_LAUNCH;
                    sss_pkg::OP_LOADV:  cmd.op = sss_pkg::DP_LOADV;
                    default:            cmd.op = sss_pkg::DP_NONE;
                endcase
            end
            S_DIFF:      cmd.op = sss_pkg::DP_DIFF;
            S_MAG:       cmd.op = sss_pkg::DP_MAG;
            S_SHIFT:     cmd.op = sss_pkg::DP_SHIFT;
            S_SQ:        cmd.op = sss_pkg::DP_SQ;
            S_ACC:       cmd.op = sss_pkg::DP_ACC;
            S_LIM:       cmd.op = sss_pkg::DP_LIMSQ;
            S_DECIDE:
            begin
                if (phase_reg == PH_HIT)
                begin
                    cmd.op = sss_pkg::DP_HIT;
                end
            end
            S_TLATCH:    cmd.op = sss_pkg::DP_TLATCH;
            S_ZERO:      cmd.op = sss_pkg::DP_ZERO;
            S_SQRT_INIT: cmd.op = sss_pkg::DP_SQRT_INIT;
            S_SQRT:      cmd.op = sss_pkg::DP_SQRT_STEP;
            S_MULQ:      cmd.op = sss_pkg::DP_MULQ;
            S_DIV_INIT:  cmd.op = sss_pkg::DP_DIV_INIT;
            S_DIV:       cmd.op = sss_pkg::DP_DIV_STEP;
            S_STORE:     cmd.op = sss_pkg::DP_STORE;
            S_NEXT:
            begin
                unique case (phase_reg)
                    PH_DESIRE: cmd.op = sss_pkg::DP_SUBV;
                    PH_FORCE:  cmd.op = sss_pkg::DP_ADDV;
                    default:   cmd.op = sss_pkg::DP_SETV;
                endcase
            end
            S_MOVE:      cmd.op = sss_pkg::DP_MOVE;
            S_OUT:
            begin
                if (out_load)
                begin
                    cmd.op = sss_pkg::DP_OUT;
                end
            end
            default:     cmd.op = sss_pkg::DP_NONE;
        endcase
    end

    // State, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HIT;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result taken and no new word loaded this cycle
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (sts.opcode == sss_pkg::OP_TICK)
                    begin
                        phase_reg <= PH_HIT;
                        state_reg <= S_DIFF;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (sts.mag_small)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (idx_reg == 2'(sss_pkg::LAST_IDX))
                    begin
                        state_reg <= S_LIM;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_SQ;
                    end
                end
                S_LIM:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    unique case (phase_reg)
                        PH_HIT:
                        begin
                            state_reg <= S_TLATCH;
                        end
                        PH_DESIRE:
                        begin
                            state_reg <= sts.acc_zero ? S_ZERO : S_SQRT_INIT;
                        end
                        default:
                        begin
                            state_reg <= (sts.big || sts.acc_gt) ? S_SQRT_INIT : S_NEXT;
                        end
                    endcase
                end
                S_TLATCH:
                begin
                    phase_reg <= PH_DESIRE;
                    state_reg <= S_DIFF;
                end
                S_ZERO:
                begin
                    state_reg <= S_NEXT;
                end
                S_SQRT_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == sss_pkg::CNT_W'(sss_pkg::SQRT_STEPS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_MULQ;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_MULQ:
                begin
                    state_reg <= S_DIV_INIT;
                end
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == sss_pkg::CNT_W'(sss_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_STORE:
                begin
                    if (idx_reg == 2'(sss_pkg::LAST_IDX))
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_MULQ;
                    end
                end
                S_NEXT:
                begin
                    unique case (phase_reg)
                        PH_DESIRE:
                        begin
                            phase_reg <= PH_FORCE;
                            state_reg <= S_MAG;
                        end
                        PH_FORCE:
                        begin
                            phase_reg <= PH_SPEED;
                            state_reg <= S_MAG;
                        end
                        default:
                        begin
                            state_reg <= S_MOVE;
                        end
                    endcase
                end
                S_MOVE:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/sss_dpath.sv
`timescale 1ns / 1ps

module sss_dpath #(
    parameter int COORD_WIDTH = sss_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sss_pkg::CFG_W-1:0]         cfg_data,
    input  logic [1:0]                        opcode,
    input  logic signed [sss_pkg::IN_W-1:0]   vec_x,
    input  logic signed [sss_pkg::IN_W-1:0]   vec_y,
    input  logic signed [sss_pkg::IN_W-1:0]   vec_z,
    input  logic                              target_present,
    input  sss_pkg::cmd_t                     cmd,
    output sss_pkg::sts_t                     sts,
    output logic signed [sss_pkg::IN_W-1:0]   pos_x,
    output logic signed [sss_pkg::IN_W-1:0]   pos_y,
    output logic signed [sss_pkg::IN_W-1:0]   pos_z,
    output logic signed [sss_pkg::IN_W-1:0]   vel_x,
    output logic signed [sss_pkg::IN_W-1:0]   vel_y,
    output logic signed [sss_pkg::IN_W-1:0]   vel_z,
    output logic                              is_active,
    output logic                              hit
);

    localparam int CW = COORD_WIDTH;
    // Working width: holds any difference or sum of stored vectors
    localparam int DW = ((CW > sss_pkg::IN_W) ? CW : sss_pkg::IN_W) + 2;
    localparam int N  = sss_pkg::VEC_N;
    localparam int MW = sss_pkg::MUL_W;
    localparam int PW = sss_pkg::PROD_W;
    localparam int AW = sss_pkg::ACC_W;
    localparam int RW = sss_pkg::ROOT_W;
    localparam int EW = sss_pkg::REM_W;
    localparam int IW = sss_pkg::IN_W;

    // Saturate a working value to the stored coordinate width
    function automatic logic signed [CW-1:0] sat_cw(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] lo;
        logic signed [CW-1:0] r;
        hi = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            r = hi[CW-1:0];
        end
        else if (v < lo)
        begin
            r = lo[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // Configuration
    logic [sss_pkg::CFG_W-1:0] max_speed_reg;
    logic [sss_pkg::CFG_W-1:0] max_force_reg;
    logic [sss_pkg::CFG_W-1:0] hit_radius_reg;

    // Architectural state
    logic signed [CW-1:0] pos_reg [N];
    logic signed [CW-1:0] vel_reg [N];
    logic signed [IW-1:0] tgt_reg [N];
    logic                 active_reg;
    logic                 hit_reg;

    // Captured input word
    logic [1:0]           in_op_reg;
    logic signed [IW-1:0] in_vec_reg [N];
    logic                 in_tp_reg;

    // Working vector and its magnitudes
    logic signed [DW-1:0] vec_reg  [N];
    logic [DW-1:0]        mag_reg  [N];
    logic                 sign_reg [N];
    logic                 big_reg;

    // Multiplier, accumulator, root and divider
    logic [PW-1:0] prod_reg;
    logic [AW-1:0] acc_reg;
    logic [AW-1:0] rad_reg;
    logic [EW-1:0] srem_reg;
    logic [RW-1:0] root_reg;
    logic [RW-1:0] drem_reg;
    logic [MW-1:0] dsh_reg;

    // Result word
    logic [IW-1:0] out_pos_reg [N];
    logic [IW-1:0] out_vel_reg [N];
    logic          out_active_reg;
    logic          out_hit_reg;

    logic signed [DW-1:0] in_ext  [N];
    logic signed [DW-1:0] tgt_ext [N];
    logic signed [DW-1:0] pos_ext [N];
    logic signed [DW-1:0] vel_ext [N];
    logic signed [DW-1:0] sat_vec_ext [N];
    logic                 mag_small;
    logic [MW-1:0]        lim_val;
    logic [DW-1:0]        mag_sel;
    logic                 sign_sel;
    logic [MW-1:0]        mul_a;
    logic [MW-1:0]        mul_b;
    logic [EW+1:0]        sq_t;
    logic [EW-1:0]        sq_trial;
    logic [EW-1:0]        srem_next;
    logic [RW-1:0]        root_next;
    logic [RW:0]          dv_t;
    logic [RW-1:0]        drem_next;
    logic                 qbit;
    logic signed [DW-1:0] quo_ext;
    logic signed [DW-1:0] store_val;

    // Sign extension of the various vectors to working width
    always_comb
    begin
        in_ext[0] = {{(DW-IW){in_vec_reg[0][IW-1]}}, in_vec_reg[0]};
        in_ext[1] = {{(DW-IW){in_vec_reg[1][IW-1]}}, in_vec_reg[1]};
        in_ext[2] = {{(DW-IW){in_vec_reg[2][IW-1]}}, in_vec_reg[2]};
        for (int i = 0; i < N; i++)
        begin
            tgt_ext[i]     = {{(DW-IW){tgt_reg[i][IW-1]}}, tgt_reg[i]};
            pos_ext[i]     = {{(DW-CW){pos_reg[i][CW-1]}}, pos_reg[i]};
            vel_ext[i]     = {{(DW-CW){vel_reg[i][CW-1]}}, vel_reg[i]};
        end
    end

    // Saturated working vector, used for the velocity update
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            sat_vec_ext[i] = DW'(sat_cw(vec_reg[i]));
        end
    end

    // All magnitudes below 2^31
    always_comb
    begin
        mag_small = 1'b1;
        for (int i = 0; i < N; i++)
        begin
            if (mag_reg[i][DW-1:MW] != '0)
            begin
                mag_small = 1'b0;
            end
        end
    end

    // Limit and component select
    always_comb
    begin
        unique case (cmd.lim)
            sss_pkg::LIM_FORCE:  lim_val = max_force_reg;
            sss_pkg::LIM_RADIUS: lim_val = hit_radius_reg;
            default:             lim_val = max_speed_reg;
        endcase
        case (cmd.idx)
            2'd1:
            begin
                mag_sel  = mag_reg[1];
                sign_sel = sign_reg[1];
            end
            2'd2:
            begin
                mag_sel  = mag_reg[2];
                sign_sel = sign_reg[2];
            end
            default:
            begin
                mag_sel  = mag_reg[0];
                sign_sel = sign_reg[0];
            end
        endcase
    end

    // Multiplier operand select
    always_comb
    begin
        case (cmd.op)
            sss_pkg::DP_SQ:
            begin
                mul_a = mag_sel[MW-1:0];
                mul_b = mag_sel[MW-1:0];
            end
            sss_pkg::DP_MULQ:
            begin
                mul_a = mag_sel[MW-1:0];
                mul_b = lim_val;
            end
            default:
            begin
                mul_a = lim_val;
                mul_b = lim_val;
            end
        endcase
    end

    // One root bit per step
    always_comb
    begin
        sq_t     = {srem_reg, rad_reg[AW-1:AW-2]};
        sq_trial = {root_reg, 2'b01};
        if (sq_t >= (EW+2)'(sq_trial))
        begin
            srem_next = EW'(sq_t - (EW+2)'(sq_trial));
            root_next = {root_reg[RW-2:0], 1'b1};
        end
        else
        begin
            srem_next = sq_t[EW-1:0];
            root_next = {root_reg[RW-2:0], 1'b0};
        end
    end

    // One quotient bit per step; quotient never exceeds the limit
    always_comb
    begin
        dv_t = {drem_reg, dsh_reg[MW-1]};
        if (dv_t >= (RW+1)'(root_reg))
        begin
            drem_next = RW'(dv_t - (RW+1)'(root_reg));
            qbit      = 1'b1;
        end
        else
        begin
            drem_next = dv_t[RW-1:0];
            qbit      = 1'b0;
        end
        quo_ext   = {{(DW-MW){1'b0}}, dsh_reg};
        store_val = sign_sel ? -quo_ext : quo_ext;
    end

    assign sts.opcode    = in_op_reg;
    assign sts.mag_small = mag_small;
    assign sts.big       = big_reg;
    assign sts.acc_zero  = (acc_reg == '0);
    assign sts.acc_gt    = (acc_reg > AW'(prod_reg));

    // Configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg  <= '0;
            max_force_reg  <= '0;
            hit_radius_reg <= sss_pkg::HIT_RADIUS_RST;
            for (int i = 0; i < N; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
            active_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sss_pkg::REG_MAX_SPEED:  max_speed_reg  <= cfg_data;
                    sss_pkg::REG_MAX_FORCE:  max_force_reg  <= cfg_data;
                    sss_pkg::REG_HIT_RADIUS: hit_radius_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                sss_pkg::DP_CAPTURE:
                begin
                    hit_reg <= 1'b0;
                end
                sss_pkg::DP_LAUNCH:
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        pos_reg[i] <= sat_cw(in_ext[i]);
                        vel_reg[i] <= '0;
                    end
                    active_reg <= 1'b1;
                end
                sss_pkg::DP_LOADV:
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        vel_reg[i] <= sat_cw(in_ext[i]);
                    end
                end
                sss_pkg::DP_HIT:
                begin
                    if (!big_reg && (acc_reg < AW'(prod_reg)))
                    begin
                        hit_reg    <= 1'b1;
                        active_reg <= 1'b0;
                    end
                end
                sss_pkg::DP_TLATCH:
                begin
                    if (in_tp_reg)
                    begin
                        for (int i = 0; i < N; i++)
                        begin
                            tgt_reg[i] <= in_vec_reg[i];
                        end
                    end
                end
                sss_pkg::DP_SETV:
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        vel_reg[i] <= sat_cw(vec_reg[i]);
                    end
                end
                sss_pkg::DP_MOVE:
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        pos_reg[i] <= sat_cw(pos_ext[i] + vel_ext[i]);
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sss_pkg::DP_CAPTURE:
            begin
                in_op_reg     <= opcode;
                in_vec_reg[0] <= vec_x;
                in_vec_reg[1] <= vec_y;
                in_vec_reg[2] <= vec_z;
                in_tp_reg     <= target_present;
            end
            sss_pkg::DP_DIFF:
            begin
                for (int i = 0; i < N; i++)
                begin
                    vec_reg[i] <= tgt_ext[i] - pos_ext[i];
                end
            end
            sss_pkg::DP_MAG:
            begin
                for (int i = 0; i < N; i++)
                begin
                    mag_reg[i]  <= vec_reg[i][DW-1] ? DW'(-vec_reg[i]) : DW'(vec_reg[i]);
                    sign_reg[i] <= vec_reg[i][DW-1];
                end
                big_reg <= 1'b0;
                acc_reg <= '0;
            end
            sss_pkg::DP_SHIFT:
            begin
                if (!mag_small)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    big_reg <= 1'b1;
                end
            end
            sss_pkg::DP_SQ, sss_pkg::DP_LIMSQ, sss_pkg::DP_MULQ:
            begin
                prod_reg <= PW'(mul_a) * PW'(mul_b);
            end
            sss_pkg::DP_ACC:
            begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
            sss_pkg::DP_ZERO:
            begin
                for (int i = 0; i < N; i++)
                begin
                    vec_reg[i] <= '0;
                end
            end
            sss_pkg::DP_SQRT_INIT:
            begin
                rad_reg  <= acc_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            sss_pkg::DP_SQRT_STEP:
            begin
                rad_reg  <= rad_reg << 2;
                srem_reg <= srem_next;
                root_reg <= root_next;
            end
            sss_pkg::DP_DIV_INIT:
            begin
                drem_reg <= RW'(prod_reg[PW-1:MW]);
                dsh_reg  <= prod_reg[MW-1:0];
            end
            sss_pkg::DP_DIV_STEP:
            begin
                drem_reg <= drem_next;
                dsh_reg  <= {dsh_reg[MW-2:0], qbit};
            end
            sss_pkg::DP_STORE:
            begin
                case (cmd.idx)
                    2'd1:    vec_reg[1] <= store_val;
                    2'd2:    vec_reg[2] <= store_val;
                    default: vec_reg[0] <= store_val;
                endcase
            end
            sss_pkg::DP_SUBV:
            begin
                for (int i = 0; i < N; i++)
                begin
                    vec_reg[i] <= vec_reg[i] - vel_ext[i];
                end
            end
            sss_pkg::DP_ADDV:
            begin
                for (int i = 0; i < N; i++)
                begin
                    vec_reg[i] <= vec_reg[i] + vel_ext[i];
                end
            end
            sss_pkg::DP_SETV:
            begin
                for (int i = 0; i < N; i++)
                begin
                    vec_reg[i] <= sat_vec_ext[i];
                end
            end
            sss_pkg::DP_OUT:
            begin
                for (int i = 0; i < N; i++)
                begin
                    out_pos_reg[i] <= pos_ext[i][IW-1:0];
                    out_vel_reg[i] <= vel_ext[i][IW-1:0];
                end
                out_active_reg <= active_reg;
                out_hit_reg    <= hit_reg;
            end
            default: ;
        endcase
    end

    assign pos_x     = out_pos_reg[0];
    assign pos_y     = out_pos_reg[1];
    assign pos_z     = out_pos_reg[2];
    assign vel_x     = out_vel_reg[0];
    assign vel_y     = out_vel_reg[1];
    assign vel_z     = out_vel_reg[2];
    assign is_active = out_active_reg;
    assign hit       = out_hit_reg;

endmodule

// File: hw/rtl/sss_checker.sv
`timescale 1ns / 1ps

module sss_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [sss_pkg::IN_W-1:0]   pos_x,
    input logic signed [sss_pkg::IN_W-1:0]   vel_x,
    input logic                              is_active,
    input logic                              hit
);

    // A stalled result word stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word holds its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pos_x) && $stable(vel_x)
                                    && $stable(is_active) && $stable(hit))
        else $error("result word changed while stalled");

    // A hit always deactivates the point
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !is_active)
        else $error("hit reported with point still active");

    // One word in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous word still in work");

endmodule

bind seek_steering_step sss_checker u_sss_checker (.*);
